>>> sv/rtca_pkg.sv
package rtca_pkg;

  localparam logic [2:0] FUNC_TICK   = 3'd0;
  localparam logic [2:0] FUNC_NEXT   = 3'd1;
  localparam logic [2:0] FUNC_INCR   = 3'd2;
  localparam logic [2:0] FUNC_TOGGLE = 3'd3;
  localparam logic [2:0] FUNC_FINISH = 3'd4;

  localparam logic [1:0] FIELD_HOUR   = 2'd0;
  localparam logic [1:0] FIELD_MINUTE = 2'd1;
  localparam logic [1:0] FIELD_SECOND = 2'd2;

  localparam logic       TARGET_TIME  = 1'b0;
  localparam logic       TARGET_ALARM = 1'b1;

  localparam logic [3:0] HOUR_NOON = 4'd12;
  localparam logic [3:0] HOUR_LAST = 4'd11;
  localparam logic [3:0] HOUR_WRAP = 4'd13;
  localparam logic [5:0] SIXTY     = 6'd60;

  typedef logic [3:0] hour_t;
  typedef logic [5:0] sixty_t;

  typedef struct packed {
    logic [2:0] func;
    logic [9:0] elapsed_ms;
    logic       edit_target;
  } item_t;

  typedef struct packed {
    hour_t      hour_now;
    sixty_t     minute_now;
    sixty_t     second_now;
    logic       is_pm;
    logic       alarm_fire;
    logic       alarm_armed;
    logic [1:0] field_selected;
  } result_t;

  typedef struct packed {
    hour_t hour;
    logic  pm;
  } hour_pm_t;

  function automatic sixty_t bump_sixty(input sixty_t v);
    sixty_t n;
    n = v + 6'd1;
    return (n >= SIXTY) ? 6'd0 : n;
  endfunction

  function automatic hour_t bump_hour(input hour_t h, input logic pm);
    hour_t v;
    v = h + 4'd1;
    if (v >= HOUR_WRAP) begin
      v = 4'd1;
    end else if (v == HOUR_NOON && !pm) begin
      v = 4'd0;
    end
    return v;
  endfunction

  function automatic hour_pm_t toggle_half(input hour_pm_t x);
    hour_pm_t r;
    r.pm   = ~x.pm;
    r.hour = x.hour;
    if (!r.pm && x.hour == HOUR_NOON) begin
      r.hour = 4'd0;
    end else if (r.pm && x.hour == 4'd0) begin
      r.hour = HOUR_NOON;
    end
    return r;
  endfunction

  function automatic hour_pm_t advance_hour(input hour_pm_t x);
    hour_pm_t r;
    r = x;
    if (!x.pm) begin
      if (x.hour >= HOUR_LAST) begin
        r.hour = HOUR_NOON;
        r.pm   = 1'b1;
      end else begin
        r.hour = x.hour + 4'd1;
      end
    end else begin
      if (x.hour >= HOUR_NOON) begin
        r.hour = 4'd1;
      end else if (x.hour == HOUR_LAST) begin
        r.hour = 4'd0;
        r.pm   = 1'b0;
      end else begin
        r.hour = x.hour + 4'd1;
      end
    end
    return r;
  endfunction

endpackage

>>> sv/twelve_hour_clock_with_alarm.sv
// A transaction accepted into the input register goes through the core into the result
// register (input register, then result register); a waiting result register holds it back.
// Throughput: one transaction per cycle while out_ready is high; while the result register
// waits, the input register takes one more transaction and then in_ready drops.
// Reset (synchronous, active high) sets the time to 10:15:05 AM, alarm to 0:00:00 AM,
// disarmed, hour field selected, both registers empty.
module twelve_hour_clock_with_alarm import rtca_pkg::*; #(
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] func,
  input  logic [9:0] elapsed_ms,
  input  logic       edit_target,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] hour_now,
  output logic [5:0] minute_now,
  output logic [5:0] second_now,
  output logic       is_pm,
  output logic       alarm_fire,
  output logic       alarm_armed,
  output logic [1:0] field_selected
);

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    advance;
  logic    en;
  result_t next_result;
  result_t result;

  assign in_item.func        = func;
  assign in_item.elapsed_ms  = elapsed_ms;
  assign in_item.edit_target = edit_target;
  assign en                  = held_valid && advance;

  rtca_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  rtca_core #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .item   (held_item),
    .result (next_result)
  );

  rtca_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (held_valid),
    .next_result (next_result),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .advance     (advance),
    .result      (result)
  );

  assign hour_now       = result.hour_now;
  assign minute_now     = result.minute_now;
  assign second_now     = result.second_now;
  assign is_pm          = result.is_pm;
  assign alarm_fire     = result.alarm_fire;
  assign alarm_armed    = result.alarm_armed;
  assign field_selected = result.field_selected;

endmodule

>>> sv/rtca_in_stage.sv
module rtca_in_stage import rtca_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output logic  held_valid,
  output item_t held_item
);

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

>>> sv/rtca_core.sv
module rtca_core import rtca_pkg::*; #(
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  item_t   item,
  output result_t result
);

  localparam int         MS_W    = $clog2(TICKS_PER_SECOND);
  localparam logic [9:0]  TPS_IN  = 10'(TICKS_PER_SECOND);
  localparam logic [10:0] TPS_SUM = 11'(TICKS_PER_SECOND);

  logic [MS_W-1:0] ms_count, ms_count_next;
  sixty_t          second_count, second_count_next;
  sixty_t          minute_count, minute_count_next;
  hour_pm_t        time_hour, time_hour_next;
  sixty_t          alarm_second, alarm_second_next;
  sixty_t          alarm_minute, alarm_minute_next;
  hour_pm_t        alarm_hour, alarm_hour_next;
  logic            armed, armed_next;
  logic [1:0]      edit_field, edit_field_next;
  logic            fire;

  logic [9:0]  elapsed_c;
  logic [10:0] ms_sum;
  logic [10:0] ms_wrap;
  hour_pm_t    sel_hour, sel_hour_next;
  sixty_t      sel_minute, sel_minute_next;
  sixty_t      sel_second, sel_second_next;

  always_comb begin
    elapsed_c = (item.elapsed_ms > TPS_IN) ? TPS_IN : item.elapsed_ms;
    ms_sum    = 11'(ms_count) + 11'(elapsed_c);
    ms_wrap   = ms_sum - TPS_SUM;

    sel_hour   = (item.edit_target == TARGET_ALARM) ? alarm_hour : time_hour;
    sel_minute = (item.edit_target == TARGET_ALARM) ? alarm_minute : minute_count;
    sel_second = (item.edit_target == TARGET_ALARM) ? alarm_second : second_count;
    sel_hour_next   = sel_hour;
    sel_minute_next = sel_minute;
    sel_second_next = sel_second;

    ms_count_next     = ms_count;
    second_count_next = second_count;
    minute_count_next = minute_count;
    time_hour_next    = time_hour;
    alarm_second_next = alarm_second;
    alarm_minute_next = alarm_minute;
    alarm_hour_next   = alarm_hour;
    armed_next        = armed;
    edit_field_next   = edit_field;
    fire              = 1'b0;

    unique case (item.func)
      FUNC_TICK: begin
        if (ms_sum >= TPS_SUM) begin
          ms_count_next = ms_wrap[MS_W-1:0];
          if (second_count + 6'd1 >= SIXTY) begin
            second_count_next = 6'd0;
            if (minute_count + 6'd1 >= SIXTY) begin
              minute_count_next = 6'd0;
              time_hour_next    = advance_hour(time_hour);
            end else begin
              minute_count_next = minute_count + 6'd1;
            end
          end else begin
            second_count_next = second_count + 6'd1;
          end
        end else begin
          ms_count_next = ms_sum[MS_W-1:0];
        end
        if (armed && time_hour_next == alarm_hour &&
            minute_count_next == alarm_minute && second_count_next == alarm_second) begin
          fire       = 1'b1;
          armed_next = 1'b0;
        end
      end
      FUNC_NEXT: begin
        edit_field_next = (edit_field >= FIELD_SECOND) ? FIELD_HOUR : edit_field + 2'd1;
      end
      FUNC_INCR: begin
        priority if (edit_field == FIELD_HOUR) begin
          sel_hour_next.hour = bump_hour(sel_hour.hour, sel_hour.pm);
        end else if (edit_field == FIELD_MINUTE) begin
          sel_minute_next = bump_sixty(sel_minute);
        end else begin
          sel_second_next = bump_sixty(sel_second);
        end
      end
      FUNC_TOGGLE: begin
        sel_hour_next = toggle_half(sel_hour);
      end
      FUNC_FINISH: begin
        edit_field_next = FIELD_HOUR;
        if (item.edit_target == TARGET_ALARM) begin
          armed_next = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (item.func == FUNC_INCR || item.func == FUNC_TOGGLE) begin
      if (item.edit_target == TARGET_ALARM) begin
        alarm_hour_next   = sel_hour_next;
        alarm_minute_next = sel_minute_next;
        alarm_second_next = sel_second_next;
      end else begin
        time_hour_next    = sel_hour_next;
        minute_count_next = sel_minute_next;
        second_count_next = sel_second_next;
      end
    end

    result.hour_now       = time_hour_next.hour;
    result.minute_now     = minute_count_next;
    result.second_now     = second_count_next;
    result.is_pm          = time_hour_next.pm;
    result.alarm_fire     = fire;
    result.alarm_armed    = armed_next;
    result.field_selected = edit_field_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ms_count       <= '0;
      second_count   <= 6'd5;
      minute_count   <= 6'd15;
      time_hour.hour <= 4'd10;
      time_hour.pm   <= 1'b0;
      alarm_second   <= 6'd0;
      alarm_minute   <= 6'd0;
      alarm_hour     <= '0;
      armed          <= 1'b0;
      edit_field     <= FIELD_HOUR;
    end else if (en) begin
      ms_count     <= ms_count_next;
      second_count <= second_count_next;
      minute_count <= minute_count_next;
      time_hour    <= time_hour_next;
      alarm_second <= alarm_second_next;
      alarm_minute <= alarm_minute_next;
      alarm_hour   <= alarm_hour_next;
      armed        <= armed_next;
      edit_field   <= edit_field_next;
    end
  end

endmodule

>>> sv/rtca_out_stage.sv
module rtca_out_stage import rtca_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t next_result,
  input  logic    out_ready,
  output logic    out_valid,
  output logic    advance,
  output result_t result
);

  assign advance = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && advance) begin
      result <= next_result;
    end
  end

endmodule
